@@ rtl/gcdisp_pkg.sv @@
// Shared constants, control word type and microprogram for the change dispenser.
package gcdisp_pkg;

    // Sizes of the denomination table and of all money amounts.
    localparam int MAX_DENOMS  = 16;
    localparam int AMOUNT_BITS = 20;
    localparam int IDX_W       = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
    localparam int CNT_W       = $clog2(MAX_DENOMS + 1);
    localparam int BIT_W       = $clog2(AMOUNT_BITS);

    // Request opcodes.
    localparam logic [1:0] OPC_APPEND = 2'd0;
    localparam logic [1:0] OPC_CLEAR  = 2'd1;
    localparam logic [1:0] OPC_CHANGE = 2'd2;
    localparam logic [1:0] OPC_NONE   = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_LOAD_OK  = 3'd0;
    localparam logic [2:0] KIND_LOAD_REJ = 3'd1;
    localparam logic [2:0] KIND_COIN     = 3'd2;
    localparam logic [2:0] KIND_LOW_PAY  = 3'd3;
    localparam logic [2:0] KIND_FINISHED = 3'd4;

    // Micro-operations that the control word applies to the datapath.
    localparam logic [3:0] U_NOP       = 4'd0;
    localparam logic [3:0] U_ACCEPT    = 4'd1;
    localparam logic [3:0] U_SUB       = 4'd2;
    localparam logic [3:0] U_IDX0      = 4'd3;
    localparam logic [3:0] U_RDTAB     = 4'd4;
    localparam logic [3:0] U_DIVINIT   = 4'd5;
    localparam logic [3:0] U_DIVSTEP   = 4'd6;
    localparam logic [3:0] U_EMIT_COIN = 4'd7;
    localparam logic [3:0] U_INCIDX    = 4'd8;
    localparam logic [3:0] U_EMIT_FIN  = 4'd9;
    localparam logic [3:0] U_EMIT_LOW  = 4'd10;
    localparam logic [3:0] U_APPEND    = 4'd11;
    localparam logic [3:0] U_CLEAR     = 4'd12;

    // Jump conditions.
    localparam logic [3:0] C_NEVER   = 4'd0;
    localparam logic [3:0] C_ALWAYS  = 4'd1;
    localparam logic [3:0] C_NOIN    = 4'd2;
    localparam logic [3:0] C_OP_APP  = 4'd3;
    localparam logic [3:0] C_OP_CLR  = 4'd4;
    localparam logic [3:0] C_OP_NONE = 4'd5;
    localparam logic [3:0] C_LOW     = 4'd6;
    localparam logic [3:0] C_END     = 4'd7;
    localparam logic [3:0] C_SKIP    = 4'd8;
    localparam logic [3:0] C_DIVMORE = 4'd9;

    // Microprogram addresses.
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] A_IDLE    = 4'd0;
    localparam logic [UPC_W-1:0] A_DISP0   = 4'd1;
    localparam logic [UPC_W-1:0] A_DISP1   = 4'd2;
    localparam logic [UPC_W-1:0] A_DISP2   = 4'd3;
    localparam logic [UPC_W-1:0] A_SUB     = 4'd4;
    localparam logic [UPC_W-1:0] A_IDX0    = 4'd5;
    localparam logic [UPC_W-1:0] A_LOOP    = 4'd6;
    localparam logic [UPC_W-1:0] A_TEST    = 4'd7;
    localparam logic [UPC_W-1:0] A_DIVINIT = 4'd8;
    localparam logic [UPC_W-1:0] A_DIVSTEP = 4'd9;
    localparam logic [UPC_W-1:0] A_COIN    = 4'd10;
    localparam logic [UPC_W-1:0] A_NEXT    = 4'd11;
    localparam logic [UPC_W-1:0] A_FIN     = 4'd12;
    localparam logic [UPC_W-1:0] A_LOW     = 4'd13;
    localparam logic [UPC_W-1:0] A_APPEND  = 4'd14;
    localparam logic [UPC_W-1:0] A_CLEAR   = 4'd15;

    // One control word: operation, jump condition and jump target.
    typedef struct packed {
        logic [3:0]       uop;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    // The microprogram. A taken condition jumps to target, else the step
    // counter advances by one.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t cw;
        unique case (addr)
            A_IDLE:    cw = '{U_ACCEPT,    C_NOIN,    A_IDLE};
            A_DISP0:   cw = '{U_NOP,       C_OP_APP,  A_APPEND};
            A_DISP1:   cw = '{U_NOP,       C_OP_CLR,  A_CLEAR};
            A_DISP2:   cw = '{U_NOP,       C_OP_NONE, A_IDLE};
            A_SUB:     cw = '{U_SUB,       C_LOW,     A_LOW};
            A_IDX0:    cw = '{U_IDX0,      C_NEVER,   A_IDLE};
            A_LOOP:    cw = '{U_RDTAB,     C_END,     A_FIN};
            A_TEST:    cw = '{U_NOP,       C_SKIP,    A_NEXT};
            A_DIVINIT: cw = '{U_DIVINIT,   C_NEVER,   A_IDLE};
            A_DIVSTEP: cw = '{U_DIVSTEP,   C_DIVMORE, A_DIVSTEP};
            A_COIN:    cw = '{U_EMIT_COIN, C_NEVER,   A_IDLE};
            A_NEXT:    cw = '{U_INCIDX,    C_ALWAYS,  A_LOOP};
            A_FIN:     cw = '{U_EMIT_FIN,  C_ALWAYS,  A_IDLE};
            A_LOW:     cw = '{U_EMIT_LOW,  C_ALWAYS,  A_IDLE};
            A_APPEND:  cw = '{U_APPEND,    C_ALWAYS,  A_IDLE};
            A_CLEAR:   cw = '{U_CLEAR,     C_ALWAYS,  A_IDLE};
            default:   cw = '{U_NOP,       C_ALWAYS,  A_IDLE};
        endcase
        return cw;
    endfunction

endpackage

@@ rtl/greedy_change_dispenser.sv @@
// Greedy change dispenser: microcoded sequencer over a denomination table.
//
// Requests load denominations (largest first), clear the table, or make change for a
// price and a payment. An append, a clear and a payment that is too low each give a
// single result; the unused opcode returns to idle with none. A change request runs
// accept, dispatch, subtract and walk setup, then for each table entry reads it and
// tests it, skipping entries that are zero or larger than the rest, and for each
// denomination paid out runs the restoring divider, which retires one quotient bit a
// cycle, and emits a coin result; a final end-of-table test leads to the finished
// result. A new request is taken only when the sequencer is back at its idle step. One
// output register holds the next result, and the sequencer waits at a result step while
// that register is still full.
module greedy_change_dispenser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [1:0]                          opcode,
    input  logic [gcdisp_pkg::AMOUNT_BITS-1:0]  denomination,
    input  logic [gcdisp_pkg::AMOUNT_BITS-1:0]  price,
    input  logic [gcdisp_pkg::AMOUNT_BITS-1:0]  payment,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [2:0]                          kind,
    output logic [gcdisp_pkg::AMOUNT_BITS-1:0]  coin_value,
    output logic [gcdisp_pkg::AMOUNT_BITS-1:0]  coin_count,
    output logic [gcdisp_pkg::AMOUNT_BITS-1:0]  unpaid_rest,
    output logic                                last
);
    import gcdisp_pkg::*;

    // Sequencer and control registers.
    logic [UPC_W-1:0]       upc_reg, upc_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // Datapath registers.
    logic [1:0]             opc_reg, opc_next;
    logic [AMOUNT_BITS-1:0] denom_reg, denom_next;
    logic [AMOUNT_BITS-1:0] price_reg, price_next;
    logic [AMOUNT_BITS-1:0] pay_reg, pay_next;
    logic [AMOUNT_BITS-1:0] last_denom_reg, last_denom_next;
    logic [AMOUNT_BITS-1:0] rest_reg, rest_next;
    logic [AMOUNT_BITS-1:0] d_reg;
    logic [AMOUNT_BITS-1:0] rem_reg, rem_next;
    logic [AMOUNT_BITS-1:0] quot_reg, quot_next;
    logic [AMOUNT_BITS-1:0] dvd_reg, dvd_next;

    // Result register.
    logic [2:0]             kind_reg, kind_next;
    logic [AMOUNT_BITS-1:0] coin_value_reg, coin_value_next;
    logic [AMOUNT_BITS-1:0] coin_count_reg, coin_count_next;
    logic [AMOUNT_BITS-1:0] unpaid_rest_reg, unpaid_rest_next;
    logic                   last_reg, last_next;

    // Denomination table.
    logic [AMOUNT_BITS-1:0] denom_mem [MAX_DENOMS];
    logic                   tab_we;
    logic                   tab_re;

    // Decode and condition signals.
    ucode_t                 cw;
    logic                   cond_hit;
    logic                   emit_op;
    logic                   stall;
    logic                   append_ok;
    logic [AMOUNT_BITS:0]   trial;
    logic [AMOUNT_BITS:0]   trial_diff;
    logic                   trial_ge;

    assign req_ready   = (upc_reg == A_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign kind        = kind_reg;
    assign coin_value  = coin_value_reg;
    assign coin_count  = coin_count_reg;
    assign unpaid_rest = unpaid_rest_reg;
    assign last        = last_reg;

    // Fetch the control word of the current step.
    assign cw = ucode_rom(upc_reg);

    // Append check: nonzero, room left, and not larger than the previous entry.
    assign append_ok = (denom_reg != '0) && (count_reg < CNT_W'(MAX_DENOMS))
                       && ((count_reg == '0) || (denom_reg <= last_denom_reg));

    // One restoring division step: bring down the next dividend bit and try a subtract.
    assign trial      = {rem_reg, dvd_reg[AMOUNT_BITS-1]};
    assign trial_diff = trial - {1'b0, d_reg};
    assign trial_ge   = (trial >= {1'b0, d_reg});

    // Jump condition select.
    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:   cond_hit = 1'b0;
            C_ALWAYS:  cond_hit = 1'b1;
            C_NOIN:    cond_hit = !req_valid;
            C_OP_APP:  cond_hit = (opc_reg == OPC_APPEND);
            C_OP_CLR:  cond_hit = (opc_reg == OPC_CLEAR);
            C_OP_NONE: cond_hit = (opc_reg == OPC_NONE);
            C_LOW:     cond_hit = (pay_reg < price_reg);
            C_END:     cond_hit = (rest_reg == '0) || (idx_reg >= count_reg);
            C_SKIP:    cond_hit = (d_reg == '0) || (d_reg > rest_reg);
            C_DIVMORE: cond_hit = (bit_reg != '0);
            default:   cond_hit = 1'b1;
        endcase
    end

    // Steps that write the result register wait while it is still full.
    assign emit_op = (cw.uop == U_EMIT_COIN) || (cw.uop == U_EMIT_FIN)
                     || (cw.uop == U_EMIT_LOW) || (cw.uop == U_APPEND)
                     || (cw.uop == U_CLEAR);
    assign stall   = emit_op && rsp_valid_reg && !rsp_ready;

    // Datapath actions of the current control word.
    always_comb
    begin
        upc_next         = upc_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        bit_next         = bit_reg;
        opc_next         = opc_reg;
        denom_next       = denom_reg;
        price_next       = price_reg;
        pay_next         = pay_reg;
        last_denom_next  = last_denom_reg;
        rest_next        = rest_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        dvd_next         = dvd_reg;
        kind_next        = kind_reg;
        coin_value_next  = coin_value_reg;
        coin_count_next  = coin_count_reg;
        unpaid_rest_next = unpaid_rest_reg;
        last_next        = last_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        tab_we           = 1'b0;
        tab_re           = 1'b0;

        if (!stall)
        begin
            upc_next = cond_hit ? cw.target : upc_reg + UPC_W'(1);
            unique case (cw.uop)
                U_NOP:
                begin
                end
                U_ACCEPT:
                begin
                    if (req_valid)
                    begin
                        opc_next   = opcode;
                        denom_next = denomination;
                        price_next = price;
                        pay_next   = payment;
                    end
                end
                U_SUB:
                begin
                    rest_next = pay_reg - price_reg;
                end
                U_IDX0:
                begin
                    idx_next = '0;
                end
                U_RDTAB:
                begin
                    tab_re = 1'b1;
                end
                U_DIVINIT:
                begin
                    dvd_next  = rest_reg;
                    rem_next  = '0;
                    quot_next = '0;
                    bit_next  = BIT_W'(AMOUNT_BITS - 1);
                end
                U_DIVSTEP:
                begin
                    rem_next  = trial_ge ? trial_diff[AMOUNT_BITS-1:0]
                                         : trial[AMOUNT_BITS-1:0];
                    quot_next = {quot_reg[AMOUNT_BITS-2:0], trial_ge};
                    dvd_next  = {dvd_reg[AMOUNT_BITS-2:0], 1'b0};
                    bit_next  = bit_reg - BIT_W'(1);
                end
                U_EMIT_COIN:
                begin
                    rest_next        = rem_reg;
                    rsp_valid_next   = 1'b1;
                    kind_next        = KIND_COIN;
                    coin_value_next  = d_reg;
                    coin_count_next  = quot_reg;
                    unpaid_rest_next = '0;
                    last_next        = 1'b0;
                end
                U_INCIDX:
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                U_EMIT_FIN:
                begin
                    rsp_valid_next   = 1'b1;
                    kind_next        = KIND_FINISHED;
                    coin_value_next  = '0;
                    coin_count_next  = '0;
                    unpaid_rest_next = rest_reg;
                    last_next        = 1'b1;
                end
                U_EMIT_LOW:
                begin
                    rsp_valid_next   = 1'b1;
                    kind_next        = KIND_LOW_PAY;
                    coin_value_next  = '0;
                    coin_count_next  = '0;
                    unpaid_rest_next = '0;
                    last_next        = 1'b1;
                end
                U_APPEND:
                begin
                    rsp_valid_next   = 1'b1;
                    kind_next        = append_ok ? KIND_LOAD_OK : KIND_LOAD_REJ;
                    coin_value_next  = '0;
                    coin_count_next  = '0;
                    unpaid_rest_next = '0;
                    last_next        = 1'b1;
                    if (append_ok)
                    begin
                        tab_we          = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        last_denom_next = denom_reg;
                    end
                end
                U_CLEAR:
                begin
                    count_next       = '0;
                    rsp_valid_next   = 1'b1;
                    kind_next        = KIND_LOAD_OK;
                    coin_value_next  = '0;
                    coin_count_next  = '0;
                    unpaid_rest_next = '0;
                    last_next        = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        bit_reg         <= bit_next;
        opc_reg         <= opc_next;
        denom_reg       <= denom_next;
        price_reg       <= price_next;
        pay_reg         <= pay_next;
        last_denom_reg  <= last_denom_next;
        rest_reg        <= rest_next;
        rem_reg         <= rem_next;
        quot_reg        <= quot_next;
        dvd_reg         <= dvd_next;
        kind_reg        <= kind_next;
        coin_value_reg  <= coin_value_next;
        coin_count_reg  <= coin_count_next;
        unpaid_rest_reg <= unpaid_rest_next;
        last_reg        <= last_next;
    end

    // Denomination table: write at the fill count, registered read at the walk index.
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            denom_mem[count_reg[IDX_W-1:0]] <= denom_reg;
        end
        if (tab_re)
        begin
            d_reg <= denom_mem[idx_reg[IDX_W-1:0]];
        end
    end

endmodule
